>>> rtl/ssr_pkg.sv
package ssr_pkg;

    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_READ  = 2'd1,
        MODE_WRITE = 2'd2,
        MODE_IDLE  = 2'd3
    } mode_t;

    // Register offsets inside one stream's six-register group.
    localparam logic [2:0] REG_CHAN_LO = 3'd0;
    localparam logic [2:0] REG_CHAN_HI = 3'd1;
    localparam logic [2:0] REG_PCOUNT  = 3'd2;
    localparam logic [2:0] REG_PLATCH  = 3'd3;
    localparam logic [2:0] REG_DLATCH  = 3'd4;
    localparam logic [2:0] REG_STATUS  = 3'd5;

    // Window offsets of the stream groups and the shared registers.
    localparam logic [4:0] ADDR_STREAM1   = 5'd6;
    localparam logic [4:0] ADDR_SHARED    = 5'd12;
    localparam logic [4:0] ADDR_LED       = 5'd12;
    localparam logic [4:0] ADDR_UNKNOWN   = 5'd13;
    localparam logic [4:0] ADDR_GSTATUS   = 5'd14;
    localparam logic [4:0] ADDR_SOUNDLINK = 5'd15;
    localparam logic [4:0] ADDR_SERIAL0   = 5'd16;
    localparam logic [4:0] ADDR_SERIAL1   = 5'd17;

    localparam logic [7:0] GSTATUS_VALUE   = 8'h10;
    localparam logic [7:0] SOUNDLINK_RESET = 8'h80;
    localparam logic [7:0] LED_MASK        = 8'h0F;
    localparam logic [7:0] CHAN_HI_MASK    = 8'h3F;
    localparam logic [7:0] FLAG_FIRST      = 8'h10;
    localparam logic [7:0] FLAG_LAST       = 8'h80;

    localparam logic [1:0] LOAD_NONE  = 2'd0;
    localparam logic [1:0] LOAD_FILE  = 2'd1;
    localparam logic [1:0] LOAD_RETRY = 2'd2;

    typedef struct packed {
        mode_t       mode;
        logic        sel;
        logic [2:0]  reg_idx;
        logic [7:0]  wdata;
        logic        dbg;
        logic [15:0] fp;
        logic [15:0] fpf;
        logic [7:0]  fbyte;
        logic [55:0] snap;
        logic        clr_status;
    } ssr_req_t;

    typedef struct packed {
        logic [7:0]  rdata;
        logic        taken;
        logic [1:0]  load;
        logic [15:0] chan;
        logic [15:0] count;
    } ssr_resp_t;

endpackage

>>> rtl/ssr_stream.sv
module ssr_stream #(
    parameter int PACKET_BYTES = 22,
    parameter int QUEUE_CAP    = 128
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  ssr_pkg::ssr_req_t   req,
    output ssr_pkg::ssr_resp_t  resp
);
    import ssr_pkg::*;

    localparam logic [7:0] QCAP     = 8'(QUEUE_CAP);
    localparam logic [7:0] MOD_LAST = 8'(PACKET_BYTES - 1);

    logic [15:0] chan_reg, chan_next;
    logic [15:0] cnt_reg, cnt_next;
    logic        pe_reg, pe_next;
    logic        de_reg, de_next;
    logic [7:0]  pp_reg, pp_next;
    logic [7:0]  dp_reg, dp_next;
    logic [15:0] pl_reg, pl_next;
    logic        ff_reg, ff_next;
    logic [15:0] off_reg, off_next;
    logic [7:0]  mod_reg, mod_next;
    logic [7:0]  pb_reg, pb_next;
    logic [7:0]  status_reg, status_next;
    logic [7:0]  db_reg, db_next;
    logic [55:0] latch_reg, latch_next;
    logic        open_reg, open_next;
    logic [7:0]  rd;
    logic        taken;
    logic [1:0]  load;

    function automatic logic [7:0] time_byte(input logic [15:0] off, input logic [55:0] t);
        logic [7:0] b;
        begin
            unique case (off)
                16'd4:   b = 8'h10;
                16'd5:   b = 8'h01;
                16'd6:   b = 8'h01;
                16'd10:  b = {2'b00, t[5:0]};
                16'd11:  b = {2'b00, t[11:6]};
                16'd12:  b = {2'b00, t[17:12]};
                16'd13:  b = {2'b00, t[23:18]};
                16'd14:  b = {2'b00, t[29:24]};
                16'd15:  b = {2'b00, t[35:30]};
                16'd16:  b = t[43:36];
                16'd17:  b = t[51:44];
                default: b = 8'h00;
            endcase
            return b;
        end
    endfunction

    always_comb
    begin
        logic [7:0] pb;
        logic [7:0] pp_dec;
        logic [15:0] cnt_base;
        chan_next   = chan_reg;
        cnt_next    = cnt_reg;
        pe_next     = pe_reg;
        de_next     = de_reg;
        pp_next     = pp_reg;
        dp_next     = dp_reg;
        pl_next     = pl_reg;
        ff_next     = ff_reg;
        off_next    = off_reg;
        mod_next    = mod_reg;
        pb_next     = pb_reg;
        status_next = status_reg;
        db_next     = db_reg;
        latch_next  = latch_reg;
        open_next   = open_reg;
        rd          = 8'h00;
        taken       = 1'b0;
        load        = LOAD_NONE;
        pb          = 8'h00;
        pp_dec      = pp_reg - 8'd1;
        cnt_base    = cnt_reg;

        unique case (req.mode)
            MODE_TICK:
            begin
                if (pl_reg != 16'd0)
                begin
                    pl_next = pl_reg - 16'd1;
                    if (pe_reg && pp_reg < QCAP)
                        pp_next = pp_reg + 8'd1;
                    if (de_reg && dp_reg < QCAP)
                        dp_next = dp_reg + 8'd1;
                end
            end
            MODE_READ:
            begin
                if (req.sel)
                begin
                    unique case (req.reg_idx)
                        REG_CHAN_LO: rd = chan_reg[7:0];
                        REG_CHAN_HI: rd = chan_reg[15:8];
                        REG_PCOUNT:
                        begin
                            if (pe_reg && de_reg)
                            begin
                                if (pp_reg == 8'd0 && dp_reg == 8'd0 && !req.dbg)
                                begin
                                    off_next = 16'd0;
                                    mod_next = 8'd0;
                                    if (chan_reg == 16'd0)
                                    begin
                                        // Channel zero carries one synthesised time packet.
                                        ff_next = 1'b1;
                                        pl_next = 16'd1;
                                    end
                                    else if (req.fp != 16'd0)
                                    begin
                                        load      = LOAD_FILE;
                                        open_next = 1'b1;
                                        ff_next   = 1'b1;
                                        pl_next   = req.fp;
                                    end
                                    else
                                    begin
                                        load      = LOAD_FILE;
                                        open_next = 1'b0;
                                        if (cnt_reg != 16'd0)
                                        begin
                                            load      = LOAD_RETRY;
                                            cnt_base  = 16'd0;
                                            open_next = (req.fpf != 16'd0);
                                            if (req.fpf != 16'd0)
                                            begin
                                                ff_next = 1'b1;
                                                pl_next = req.fpf;
                                            end
                                        end
                                    end
                                    cnt_next = cnt_base + 16'd1;
                                end
                                rd = pp_reg;
                            end
                        end
                        REG_PLATCH:
                        begin
                            if (pe_reg)
                            begin
                                if (pp_reg != 8'd0 && !req.dbg)
                                begin
                                    if (ff_reg)
                                        pb = pb | FLAG_FIRST;
                                    ff_next = 1'b0;
                                    pp_next = pp_dec;
                                    if (pl_reg == 16'd0 && pp_dec == 8'd0)
                                        pb = pb | FLAG_LAST;
                                    status_next = status_reg | pb;
                                    pb_next     = pb;
                                end
                                rd = pb_next;
                            end
                        end
                        REG_DLATCH:
                        begin
                            if (de_reg)
                            begin
                                if (dp_reg != 8'd0 && !req.dbg)
                                begin
                                    if (chan_reg == 16'd0)
                                    begin
                                        if (off_reg == 16'd0)
                                        begin
                                            latch_next = req.snap;
                                            db_next    = time_byte(off_reg, req.snap);
                                        end
                                        else
                                            db_next = time_byte(off_reg, latch_reg);
                                    end
                                    else if (open_reg)
                                    begin
                                        db_next = req.fbyte;
                                        taken   = 1'b1;
                                    end
                                    off_next = off_reg + 16'd1;
                                    // The position inside the packet restarts when the
                                    // 16-bit offset wraps, since zero is a packet boundary.
                                    if (off_reg == 16'hFFFF || mod_reg == MOD_LAST)
                                        mod_next = 8'd0;
                                    else
                                        mod_next = mod_reg + 8'd1;
                                    if (mod_next == 8'd0)
                                        dp_next = dp_reg - 8'd1;
                                end
                                rd = db_next;
                            end
                        end
                        REG_STATUS:
                        begin
                            rd = status_reg;
                            if (req.clr_status && !req.dbg)
                                status_next = 8'h00;
                        end
                        default: rd = 8'h00;
                    endcase
                end
            end
            MODE_WRITE:
            begin
                if (req.sel)
                begin
                    unique case (req.reg_idx)
                        REG_CHAN_LO:
                        begin
                            if (chan_reg[7:0] != req.wdata)
                                cnt_next = 16'd0;
                            chan_next = {chan_reg[15:8] & CHAN_HI_MASK, req.wdata};
                        end
                        REG_CHAN_HI:
                        begin
                            if (chan_reg[15:8] != (req.wdata & CHAN_HI_MASK))
                                cnt_next = 16'd0;
                            chan_next = {req.wdata, chan_reg[7:0]};
                        end
                        REG_PLATCH:
                        begin
                            pe_next = (req.wdata != 8'h00);
                            pp_next = 8'd0;
                        end
                        REG_DLATCH:
                        begin
                            de_next = (req.wdata != 8'h00);
                            dp_next = 8'd0;
                        end
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_reg   <= '0;
            cnt_reg    <= '0;
            pe_reg     <= 1'b0;
            de_reg     <= 1'b0;
            pp_reg     <= '0;
            dp_reg     <= '0;
            pl_reg     <= '0;
            ff_reg     <= 1'b0;
            off_reg    <= '0;
            mod_reg    <= '0;
            pb_reg     <= '0;
            status_reg <= '0;
            db_reg     <= '0;
            latch_reg  <= '0;
            open_reg   <= 1'b0;
        end
        else if (en)
        begin
            chan_reg   <= chan_next;
            cnt_reg    <= cnt_next;
            pe_reg     <= pe_next;
            de_reg     <= de_next;
            pp_reg     <= pp_next;
            dp_reg     <= dp_next;
            pl_reg     <= pl_next;
            ff_reg     <= ff_next;
            off_reg    <= off_next;
            mod_reg    <= mod_next;
            pb_reg     <= pb_next;
            status_reg <= status_next;
            db_reg     <= db_next;
            latch_reg  <= latch_next;
            open_reg   <= open_next;
        end
    end

    assign resp.rdata = rd;
    assign resp.taken = taken;
    assign resp.load  = load;
    assign resp.chan  = chan_next;
    assign resp.count = cnt_next;

endmodule

>>> rtl/satellite_stream_receiver_regs.sv
// Channel | Handshake            | Payload
// input   | in_valid / in_ready  | mode addr wdata debugger file_packets file_packets_first
//         |                      | file_byte clock_snapshot open_bus
// output  | out_valid / out_ready| rdata byte_taken load_taken stream_index req_channel
//         |                      | req_count
// One beat in, one beat out. A beat is held in the input register, is worked on
// there and lands in the result register, so one beat can be taken every cycle
// while the output does not stall. The update of both streams' registers and of the
// shared registers is the only logic between the two registers. Reset clears all
// stream state and sets soundlink to 0x80. A stall at the output holds the result
// register and, once the input register is also full, drops in_ready.
module satellite_stream_receiver_regs #(
    parameter int PACKET_BYTES = 22,
    parameter int QUEUE_CAP    = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    input  logic [4:0]  addr,
    input  logic [7:0]  wdata,
    input  logic        debugger,
    input  logic [15:0] file_packets,
    input  logic [15:0] file_packets_first,
    input  logic [7:0]  file_byte,
    input  logic [55:0] clock_snapshot,
    input  logic [7:0]  open_bus,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  rdata,
    output logic        byte_taken,
    output logic [1:0]  load_taken,
    output logic        stream_index,
    output logic [15:0] req_channel,
    output logic [15:0] req_count
);
    import ssr_pkg::*;

    logic        in_valid_reg;
    mode_t       mode_reg;
    logic [4:0]  addr_reg;
    logic [7:0]  wdata_reg;
    logic        dbg_reg;
    logic [15:0] fp_reg;
    logic [15:0] fpf_reg;
    logic [7:0]  fbyte_reg;
    logic [55:0] snap_reg;
    logic [7:0]  obus_reg;

    logic        out_valid_reg;
    logic [7:0]  rdata_reg, rdata_next;
    logic        taken_reg, taken_next;
    logic [1:0]  load_reg, load_next;
    logic        sidx_reg, sidx_next;
    logic [15:0] chan_out_reg, chan_out_next;
    logic [15:0] cnt_out_reg, cnt_out_next;

    logic [3:0]  led_reg, led_next;
    logic [7:0]  soundlink_reg, soundlink_next;

    logic        advance;
    logic        fire;
    logic        bus_access;
    logic        is_stream;
    logic        sidx;
    logic [4:0]  off_sub;
    logic [2:0]  reg_idx;
    ssr_req_t    req0, req1;
    ssr_resp_t   resp0, resp1;

    assign advance  = !out_valid_reg || out_ready;
    assign fire     = in_valid_reg && advance;
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            addr_reg  <= '0;
            wdata_reg <= '0;
            dbg_reg   <= 1'b0;
            fp_reg    <= '0;
            fpf_reg   <= '0;
            fbyte_reg <= '0;
            snap_reg  <= '0;
            obus_reg  <= '0;
        end
        else if (in_valid && in_ready)
        begin
            mode_reg  <= mode_t'(mode);
            addr_reg  <= addr;
            wdata_reg <= wdata;
            dbg_reg   <= debugger;
            fp_reg    <= file_packets;
            fpf_reg   <= file_packets_first;
            fbyte_reg <= file_byte;
            snap_reg  <= clock_snapshot;
            obus_reg  <= open_bus;
        end
    end

    // Address decode: on reads and writes, the second stream and everything above it report stream one.
    assign bus_access = (mode_reg == MODE_READ) || (mode_reg == MODE_WRITE);
    assign sidx       = bus_access && (addr_reg >= ADDR_STREAM1);
    assign is_stream  = addr_reg < ADDR_SHARED;
    assign off_sub    = addr_reg - ADDR_STREAM1;
    assign reg_idx    = sidx ? off_sub[2:0] : addr_reg[2:0];

    always_comb
    begin
        req0.mode       = mode_reg;
        req0.sel        = bus_access && !sidx;
        req0.reg_idx    = reg_idx;
        req0.wdata      = wdata_reg;
        req0.dbg        = dbg_reg;
        req0.fp         = fp_reg;
        req0.fpf        = fpf_reg;
        req0.fbyte      = fbyte_reg;
        req0.snap       = snap_reg;
        req0.clr_status = led_reg[0];
        req1            = req0;
        req1.sel        = bus_access && sidx && is_stream;
    end

    ssr_stream #(
        .PACKET_BYTES (PACKET_BYTES),
        .QUEUE_CAP    (QUEUE_CAP)
    ) u_stream0 (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (fire),
        .req   (req0),
        .resp  (resp0)
    );

    ssr_stream #(
        .PACKET_BYTES (PACKET_BYTES),
        .QUEUE_CAP    (QUEUE_CAP)
    ) u_stream1 (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (fire),
        .req   (req1),
        .resp  (resp1)
    );

    always_comb
    begin
        led_next       = led_reg;
        soundlink_next = soundlink_reg;
        rdata_next     = 8'h00;
        if (mode_reg == MODE_READ)
        begin
            priority if (is_stream)
                rdata_next = resp0.rdata | resp1.rdata;
            else if (addr_reg == ADDR_LED)
                rdata_next = {4'h0, led_reg};
            else if (addr_reg == ADDR_UNKNOWN || addr_reg == ADDR_SERIAL0
                     || addr_reg == ADDR_SERIAL1)
                rdata_next = 8'h00;
            else if (addr_reg == ADDR_GSTATUS)
                rdata_next = GSTATUS_VALUE;
            else if (addr_reg == ADDR_SOUNDLINK)
                rdata_next = soundlink_reg;
            else
                rdata_next = obus_reg;
        end
        else if (mode_reg == MODE_WRITE)
        begin
            if (addr_reg == ADDR_LED)
                led_next = 4'(wdata_reg & LED_MASK);
            else if (addr_reg == ADDR_SOUNDLINK)
                soundlink_next = wdata_reg;
        end
        taken_next    = resp0.taken | resp1.taken;
        load_next     = resp0.load | resp1.load;
        sidx_next     = sidx;
        chan_out_next = sidx ? resp1.chan : resp0.chan;
        cnt_out_next  = sidx ? resp1.count : resp0.count;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            led_reg       <= '0;
            soundlink_reg <= SOUNDLINK_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                led_reg       <= led_next;
                soundlink_reg <= soundlink_next;
            end
            if (advance)
                out_valid_reg <= fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            rdata_reg    <= rdata_next;
            taken_reg    <= taken_next;
            load_reg     <= load_next;
            sidx_reg     <= sidx_next;
            chan_out_reg <= chan_out_next;
            cnt_out_reg  <= cnt_out_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign rdata        = rdata_reg;
    assign byte_taken   = taken_reg;
    assign load_taken   = load_reg;
    assign stream_index = sidx_reg;
    assign req_channel  = chan_out_reg;
    assign req_count    = cnt_out_reg;

endmodule

>>> rtl/ssr_checker.sv
module ssr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [7:0]  rdata,
    input logic        byte_taken,
    input logic [1:0]  load_taken,
    input logic [15:0] req_channel,
    input logic [15:0] req_count
);
    import ssr_pkg::*;

    // A stalled result beat must not move.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(rdata) && $stable(req_count))
        else $error("result beat changed while stalled");

    // A data byte and a packet load come from different registers.
    a_taken_no_load: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && byte_taken |-> load_taken == LOAD_NONE)
        else $error("byte taken together with a load");

    // A retry restarts the sequence count, so it always leaves the sequence count at one.
    a_retry_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && load_taken == LOAD_RETRY |-> req_count == 16'd1)
        else $error("retry load with wrong sequence count");

    // The time channel never asks the external source for packets.
    a_load_chan: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (load_taken == LOAD_FILE || load_taken == LOAD_RETRY)
        |-> req_channel != 16'd0)
        else $error("external load on channel zero");

endmodule

bind satellite_stream_receiver_regs ssr_checker u_ssr_checker (.*);

>>> bench/ssr_tb_pkg.sv
package ssr_tb_pkg;

    timeunit 1ns;
    timeprecision 1ps;

    import ssr_pkg::*;

    localparam int PKT_BYTES = 22;
    localparam int QCAP      = 128;

    // Window offsets that no register answers to.
    localparam logic [4:0] ADDR_UNMAPPED_FIRST = 5'd18;
    localparam logic [4:0] ADDR_UNMAPPED_LAST  = 5'd23;

    typedef struct packed {
        mode_t       mode;
        logic [4:0]  addr;
        logic [7:0]  wdata;
        logic        dbg;
        logic [15:0] fp;
        logic [15:0] fpf;
        logic [7:0]  fbyte;
        logic [55:0] snap;
        logic [7:0]  obus;
    } rx_access_t;

    typedef struct packed {
        logic [7:0]  rdata;
        logic        byte_taken;
        logic [1:0]  load_taken;
        logic        stream_index;
        logic [15:0] channel;
        logic [15:0] count;
    } rx_result_t;

    class stream_regs_checker;

        logic [15:0] chan_id [2];
        logic [15:0] seq_no [2];
        logic        pfx_on [2];
        logic        dat_on [2];
        logic [7:0]  pfx_queued [2];
        logic [7:0]  dat_queued [2];
        logic [15:0] pkts_left [2];
        logic        first_pending [2];
        logic [15:0] byte_pos [2];
        logic [7:0]  pfx_latch [2];
        logic [7:0]  status_or [2];
        logic [7:0]  dat_latch [2];
        logic [55:0] clock_latch [2];
        logic        src_open [2];
        logic [3:0]  led_bits;
        logic [7:0]  soundlink_val;

        rx_result_t awaited_results [$];
        int errors;

        function new();
            for (int k = 0; k < 2; k++)
            begin
                chan_id[k] = '0;
                seq_no[k] = '0;
                pfx_on[k] = 1'b0;
                dat_on[k] = 1'b0;
                pfx_queued[k] = '0;
                dat_queued[k] = '0;
                pkts_left[k] = '0;
                first_pending[k] = 1'b0;
                byte_pos[k] = '0;
                pfx_latch[k] = '0;
                status_or[k] = '0;
                dat_latch[k] = '0;
                clock_latch[k] = '0;
                src_open[k] = 1'b0;
            end
            led_bits = '0;
            soundlink_val = SOUNDLINK_RESET;
            errors = 0;
        endfunction

        function int outstanding();
            return awaited_results.size();
        endfunction

        // A zero packet count means there is nothing to play, and the source is closed.
        function bit open_source(int s, logic [15:0] packets);
            src_open[s] = (packets != 0);
            if (src_open[s])
            begin
                first_pending[s] = 1'b1;
                pkts_left[s] = packets;
            end
            return src_open[s];
        endfunction

        function void note_access(rx_access_t a);
            rx_result_t r;
            int sel;
            logic [4:0] rg;
            logic [55:0] t;
            r = '0;
            sel = 0;
            rg = '0;
            if (a.mode == MODE_READ || a.mode == MODE_WRITE)
            begin
                sel = (a.addr >= ADDR_STREAM1) ? 1 : 0;
                rg = (a.addr < ADDR_SHARED && sel == 1) ? a.addr - ADDR_STREAM1 : a.addr;
            end

            if (a.mode == MODE_TICK)
            begin
                for (int k = 0; k < 2; k++)
                begin
                    if (pkts_left[k] != 0)
                    begin
                        pkts_left[k]--;
                        if (pfx_on[k] && pfx_queued[k] < QCAP)
                            pfx_queued[k]++;
                        if (dat_on[k] && dat_queued[k] < QCAP)
                            dat_queued[k]++;
                    end
                end
            end
            else if (a.mode == MODE_READ)
            begin
                case (rg)
                    REG_CHAN_LO: r.rdata = chan_id[sel][7:0];
                    REG_CHAN_HI: r.rdata = chan_id[sel][15:8];
                    REG_PCOUNT:
                    begin
                        if (pfx_on[sel] && dat_on[sel])
                        begin
                            if (pfx_queued[sel] == 0 && dat_queued[sel] == 0 && !a.dbg)
                            begin
                                byte_pos[sel] = '0;
                                if (chan_id[sel] == 0)
                                begin
                                    // Channel zero carries a single made-up time packet.
                                    first_pending[sel] = 1'b1;
                                    pkts_left[sel] = 16'd1;
                                end
                                else
                                begin
                                    r.load_taken = LOAD_FILE;
                                    if (!open_source(sel, a.fp) && seq_no[sel] > 0)
                                    begin
                                        seq_no[sel] = '0;
                                        r.load_taken = LOAD_RETRY;
                                        void'(open_source(sel, a.fpf));
                                    end
                                end
                                seq_no[sel]++;
                            end
                            r.rdata = pfx_queued[sel];
                        end
                    end
                    REG_PLATCH:
                    begin
                        if (pfx_on[sel])
                        begin
                            if (pfx_queued[sel] != 0 && !a.dbg)
                            begin
                                pfx_latch[sel] = '0;
                                if (first_pending[sel])
                                begin
                                    pfx_latch[sel] |= FLAG_FIRST;
                                    first_pending[sel] = 1'b0;
                                end
                                pfx_queued[sel]--;
                                if (pkts_left[sel] == 0 && pfx_queued[sel] == 0)
                                    pfx_latch[sel] |= FLAG_LAST;
                                status_or[sel] |= pfx_latch[sel];
                            end
                            r.rdata = pfx_latch[sel];
                        end
                    end
                    REG_DLATCH:
                    begin
                        if (dat_on[sel])
                        begin
                            if (dat_queued[sel] != 0 && !a.dbg)
                            begin
                                if (chan_id[sel] == 0)
                                begin
                                    // The clock is captured on the first byte of the packet.
                                    if (byte_pos[sel] == 0)
                                        clock_latch[sel] = a.snap;
                                    t = clock_latch[sel];
                                    case (byte_pos[sel])
                                        16'd4:         dat_latch[sel] = 8'h10;
                                        16'd5, 16'd6:  dat_latch[sel] = 8'h01;
                                        16'd10:        dat_latch[sel] = {2'b00, t[5:0]};
                                        16'd11:        dat_latch[sel] = {2'b00, t[11:6]};
                                        16'd12:        dat_latch[sel] = {2'b00, t[17:12]};
                                        16'd13:        dat_latch[sel] = {2'b00, t[23:18]};
                                        16'd14:        dat_latch[sel] = {2'b00, t[29:24]};
                                        16'd15:        dat_latch[sel] = {2'b00, t[35:30]};
                                        16'd16:        dat_latch[sel] = t[43:36];
                                        16'd17:        dat_latch[sel] = t[51:44];
                                        default:       dat_latch[sel] = 8'h00;
                                    endcase
                                end
                                else if (src_open[sel])
                                begin
                                    dat_latch[sel] = a.fbyte;
                                    r.byte_taken = 1'b1;
                                end
                                byte_pos[sel]++;
                                if ((byte_pos[sel] % PKT_BYTES) == 0)
                                    dat_queued[sel]--;
                            end
                            r.rdata = dat_latch[sel];
                        end
                    end
                    REG_STATUS:
                    begin
                        r.rdata = status_or[sel];
                        if (led_bits[0] && !a.dbg)
                            status_or[sel] = '0;
                    end
                    ADDR_LED:       r.rdata = {4'b0000, led_bits};
                    ADDR_UNKNOWN:   r.rdata = '0;
                    ADDR_GSTATUS:   r.rdata = GSTATUS_VALUE;
                    ADDR_SOUNDLINK: r.rdata = soundlink_val;
                    ADDR_SERIAL0,
                    ADDR_SERIAL1:   r.rdata = '0;
                    default:        r.rdata = a.obus;
                endcase
            end
            else if (a.mode == MODE_WRITE)
            begin
                case (rg)
                    REG_CHAN_LO:
                    begin
                        if (chan_id[sel][7:0] != a.wdata)
                            seq_no[sel] = '0;
                        chan_id[sel] = {chan_id[sel][15:8] & CHAN_HI_MASK, a.wdata};
                    end
                    REG_CHAN_HI:
                    begin
                        if (chan_id[sel][15:8] != (a.wdata & CHAN_HI_MASK))
                            seq_no[sel] = '0;
                        chan_id[sel] = {a.wdata, chan_id[sel][7:0]};
                    end
                    REG_PLATCH:
                    begin
                        pfx_on[sel] = (a.wdata != 0);
                        pfx_queued[sel] = '0;
                    end
                    REG_DLATCH:
                    begin
                        dat_on[sel] = (a.wdata != 0);
                        dat_queued[sel] = '0;
                    end
                    ADDR_LED:       led_bits = 4'(a.wdata & LED_MASK);
                    ADDR_SOUNDLINK: soundlink_val = a.wdata;
                    default:        ;
                endcase
            end

            r.stream_index = sel[0];
            r.channel = chan_id[sel];
            r.count = seq_no[sel];
            awaited_results.push_back(r);
        endfunction

        function void compare_field(string what, logic [15:0] want, logic [15:0] got);
            if (got !== want)
            begin
                $display("%0t ns: %s mismatch, expected %h, actual %h",
                         $time, what, want, got);
                errors++;
            end
        endfunction

        function void check_result(rx_result_t seen);
            rx_result_t want;
            if (awaited_results.size() == 0)
            begin
                $display("%0t ns: result beat with nothing expected, actual rdata %h",
                         $time, seen.rdata);
                errors++;
                return;
            end
            want = awaited_results.pop_front();
            compare_field("rdata", want.rdata, seen.rdata);
            compare_field("byte_taken", want.byte_taken, seen.byte_taken);
            compare_field("load_taken", want.load_taken, seen.load_taken);
            compare_field("stream_index", want.stream_index, seen.stream_index);
            compare_field("req_channel", want.channel, seen.channel);
            compare_field("req_count", want.count, seen.count);
        endfunction

    endclass

endpackage

>>> bench/tb_top.sv
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import ssr_pkg::*;
    import ssr_tb_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 60;
    localparam int RANDOM_ITEMS = 750;
    localparam int TAIL_ITEMS   = 120;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  mode;
    logic [4:0]  addr;
    logic [7:0]  wdata;
    logic        debugger;
    logic [15:0] file_packets;
    logic [15:0] file_packets_first;
    logic [7:0]  file_byte;
    logic [55:0] clock_snapshot;
    logic [7:0]  open_bus;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  rdata;
    logic        byte_taken;
    logic [1:0]  load_taken;
    logic        stream_index;
    logic [15:0] req_channel;
    logic [15:0] req_count;

    rx_access_t offered;
    stream_regs_checker sb;
    bit sender_idles;
    bit receiver_idles;
    bit hold_request;
    int unsigned items_sent;
    int unsigned cycle_count;

    assign mode               = offered.mode;
    assign addr               = offered.addr;
    assign wdata              = offered.wdata;
    assign debugger           = offered.dbg;
    assign file_packets       = offered.fp;
    assign file_packets_first = offered.fpf;
    assign file_byte          = offered.fbyte;
    assign clock_snapshot     = offered.snap;
    assign open_bus           = offered.obus;

    satellite_stream_receiver_regs i_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .mode               (mode),
        .addr               (addr),
        .wdata              (wdata),
        .debugger           (debugger),
        .file_packets       (file_packets),
        .file_packets_first (file_packets_first),
        .file_byte          (file_byte),
        .clock_snapshot     (clock_snapshot),
        .open_bus           (open_bus),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .rdata              (rdata),
        .byte_taken         (byte_taken),
        .load_taken         (load_taken),
        .stream_index       (stream_index),
        .req_channel        (req_channel),
        .req_count          (req_count)
    );

    initial clk = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Payload fields that the access does not use are random.
    function automatic rx_access_t beat_for(mode_t m, logic [4:0] ad, logic [7:0] wd,
                                            logic dbg);
        rx_access_t b;
        b.mode = m;
        b.addr = ad;
        b.wdata = wd;
        b.dbg = dbg;
        b.fp = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
        b.fpf = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
        b.fbyte = 8'($urandom);
        b.snap = {24'($urandom), 32'($urandom)};
        b.obus = 8'($urandom);
        return b;
    endfunction

    // Called just after a falling edge; returns just after the falling edge that
    // follows the accepting rising edge.
    task automatic drive_access(input rx_access_t a);
        if (sender_idles && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        in_valid <= 1'b1;
        offered <= a;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic read_reg(logic [4:0] ad, logic dbg);
        drive_access(beat_for(MODE_READ, ad, 8'($urandom), dbg));
    endtask

    task automatic write_reg(logic [4:0] ad, logic [7:0] wd);
        drive_access(beat_for(MODE_WRITE, ad, wd, $urandom_range(0, 9) == 0));
    endtask

    task automatic tick();
        drive_access(beat_for(MODE_TICK, 5'($urandom_range(0, 23)), 8'($urandom),
                              1'($urandom)));
    endtask

    always @(posedge clk)
    begin : beat_monitor
        rx_result_t seen;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_access(offered);
            if (out_valid && out_ready)
            begin
                seen.rdata = rdata;
                seen.byte_taken = byte_taken;
                seen.load_taken = load_taken;
                seen.stream_index = stream_index;
                seen.channel = req_channel;
                seen.count = req_count;
                sb.check_result(seen);
            end
        end
    end

    initial
    begin : result_sink
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_ready <= 1'b0;
                for (int n = 0; n < HOLD_CYCLES; n++)
                    @(negedge clk);
            end
            else if (receiver_idles && $urandom_range(0, 4) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 6) - 1) @(negedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    initial
    begin : stimulus
        rx_access_t b;
        mode_t m;
        logic [4:0] base;
        logic [15:0] ch;
        int unsigned random_start;
        int nbytes;
        bit queue_filled;
        bit tail;

        sb = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        offered = '0;
        sender_idles = 1'b1;
        receiver_idles = 1'b1;
        hold_request = 1'b0;
        items_sent = 0;
        cycle_count = 0;
        queue_filled = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Fixed registers straight out of reset, and the unmapped part of the window.
        read_reg(ADDR_SOUNDLINK, 1'b0);
        read_reg(ADDR_GSTATUS, 1'b0);
        read_reg(ADDR_UNKNOWN, 1'b0);
        read_reg(ADDR_SERIAL1, 1'b0);
        b = beat_for(MODE_READ, ADDR_UNMAPPED_LAST, 8'h00, 1'b0);
        b.obus = 8'hFF;
        drive_access(b);
        b = beat_for(MODE_READ, ADDR_UNMAPPED_FIRST, 8'hFF, 1'b0);
        b.obus = 8'h00;
        drive_access(b);
        write_reg(ADDR_UNMAPPED_LAST, 8'hA5);
        // The debugger flag has no say over writes.
        drive_access(beat_for(MODE_WRITE, ADDR_LED, 8'hFF, 1'b1));
        read_reg(ADDR_LED, 1'b0);
        write_reg(ADDR_SOUNDLINK, 8'h00);
        read_reg(ADDR_SOUNDLINK, 1'b1);
        drive_access(beat_for(MODE_IDLE, ADDR_STREAM1 + REG_CHAN_HI, 8'hFF, 1'b0));
        write_reg(ADDR_STREAM1 + REG_PCOUNT, 8'hFF);
        read_reg(REG_PCOUNT, 1'b0);

        // One time packet on stream 0, with debugger reads that must change nothing.
        write_reg(REG_PLATCH, 8'h01);
        write_reg(REG_DLATCH, 8'h80);
        read_reg(REG_PCOUNT, 1'b0);
        tick();
        read_reg(REG_PLATCH, 1'b1);
        read_reg(REG_PLATCH, 1'b0);
        b = beat_for(MODE_READ, REG_DLATCH, 8'h00, 1'b0);
        b.snap = '1;
        drive_access(b);
        read_reg(REG_STATUS, 1'b1);
        read_reg(REG_STATUS, 1'b0);

        // Stream 1 finds no packets at count zero; the retry then loads the first-file packets.
        write_reg(ADDR_STREAM1 + REG_CHAN_HI, 8'hFF);
        write_reg(ADDR_STREAM1 + REG_PLATCH, 8'hFF);
        write_reg(ADDR_STREAM1 + REG_DLATCH, 8'h01);
        b = beat_for(MODE_READ, ADDR_STREAM1 + REG_PCOUNT, 8'h00, 1'b0);
        b.fp = '0;
        b.fpf = 16'd3;
        drive_access(b);
        b = beat_for(MODE_READ, ADDR_STREAM1 + REG_PCOUNT, 8'h00, 1'b0);
        b.fp = '0;
        b.fpf = 16'hFFFF;
        drive_access(b);

        random_start = items_sent;
        while (items_sent - random_start < RANDOM_ITEMS)
        begin
            tail = (items_sent - random_start > RANDOM_ITEMS - TAIL_ITEMS);
            sender_idles = !tail && ($urandom_range(0, 3) != 0);
            receiver_idles = !tail && ($urandom_range(0, 3) != 0);
            base = ($urandom_range(0, 1) == 1) ? ADDR_STREAM1 : 5'd0;

            if (!queue_filled && items_sent - random_start > 200)
            begin
                // Run both queues into their cap while the result side holds off.
                queue_filled = 1'b1;
                write_reg(base + REG_PLATCH, 8'h01);
                write_reg(base + REG_DLATCH, 8'h01);
                write_reg(base + REG_CHAN_LO, 8'($urandom_range(1, 255)));
                b = beat_for(MODE_READ, base + REG_PCOUNT, 8'h00, 1'b0);
                b.fp = 16'd200;
                drive_access(b);
                hold_request = 1'b1;
                repeat (QCAP + 8) tick();
                read_reg(base + REG_PCOUNT, 1'b0);
                read_reg(base + REG_PLATCH, 1'b0);
                read_reg(base + REG_STATUS, 1'b0);
                write_reg(base + REG_PLATCH, 8'h01);
                write_reg(base + REG_DLATCH, 8'h01);
            end
            else if ($urandom_range(0, 4) == 0)
            begin
                repeat ($urandom_range(1, 8))
                begin
                    case ($urandom_range(0, 5))
                        0:       m = MODE_TICK;
                        1, 2:    m = MODE_WRITE;
                        default: m = MODE_READ;
                    endcase
                    drive_access(beat_for(m, 5'($urandom_range(0, 23)), 8'($urandom),
                                          1'($urandom)));
                end
            end
            else
            begin
                // A well-formed session: set up, load, move packets, drain bytes.
                if ($urandom_range(0, 4) != 0)
                begin
                    write_reg(base + REG_PLATCH,
                              ($urandom_range(0, 9) == 0) ? 8'h00 : 8'($urandom_range(1, 255)));
                    write_reg(base + REG_DLATCH,
                              ($urandom_range(0, 9) == 0) ? 8'h00 : 8'($urandom_range(1, 255)));
                end
                if ($urandom_range(0, 3) == 0)
                    write_reg(ADDR_LED, 8'($urandom));
                if ($urandom_range(0, 1) == 0)
                begin
                    ch = ($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom);
                    write_reg(base + REG_CHAN_HI, ch[15:8]);
                    write_reg(base + REG_CHAN_LO, ch[7:0]);
                end
                b = beat_for(MODE_READ, base + REG_PCOUNT, 8'($urandom),
                             $urandom_range(0, 9) == 0);
                b.fp = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 3));
                drive_access(b);
                repeat ($urandom_range(1, 4)) tick();
                repeat ($urandom_range(1, 3))
                begin
                    read_reg(base + REG_PLATCH, $urandom_range(0, 9) == 0);
                    nbytes = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 30) : PKT_BYTES;
                    repeat (nbytes) read_reg(base + REG_DLATCH, $urandom_range(0, 19) == 0);
                end
                read_reg(base + REG_STATUS, $urandom_range(0, 9) == 0);
            end
        end

        in_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
